// ===== rtl/ccu_pkg.sv =====
// Shared constants for the correlation coefficient unit.
`default_nettype none
package ccu_pkg;
  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS = 16;
  localparam int QUOT_BITS = 32;
  localparam int ROOT_BITS = 18;
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DEGEN = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/ccu_mul.sv =====
// Sequential signed shift-add multiplier, one operand bit per cycle.
`default_nettype none
module ccu_mul #(
  parameter int PW = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic signed [PW-1:0] a,
  input  wire logic signed [PW-1:0] b,
  output logic                     done,
  output logic [2*PW-1:0]          p
);
  localparam int CNTW = (PW > 1) ? $clog2(PW) : 1;

  logic              busy;
  logic              fin;
  logic              neg;
  logic [2*PW-1:0]   ma;
  logic [PW-1:0]     mb;
  logic [2*PW-1:0]   acc;
  logic [CNTW-1:0]   cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= busy && !start && (cnt == CNTW'(PW - 1));
      if (start) begin
        ma   <= {{PW{1'b0}}, (a[PW-1] ? PW'(-a) : PW'(a))};
        mb   <= b[PW-1] ? PW'(-b) : PW'(b);
        neg  <= a[PW-1] ^ b[PW-1];
        acc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (mb[0]) begin
          acc <= acc + ma;
        end
        ma  <= ma << 1;
        mb  <= mb >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(PW - 1)) begin
          busy <= 1'b0;
        end
      end
      if (fin) begin
        p <= neg ? (2*PW)'(0) - acc : acc;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |-> !busy && !fin)
    else $error("multiplier restarted while busy");
  assert property (@(posedge clk) disable iff (rst) fin |=> done)
    else $error("multiplier result not delivered");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("multiplier done while busy");
endmodule
`default_nettype wire

// ===== rtl/correlation_coefficient_unit.sv =====
// Correlation coefficient unit: sample stores, accumulation pass and result sequencer.
//
// Items enter on in_valid/in_ready: one sample pair per cycle while loading.
// Pairs beyond MAX_SAMPLES are dropped; last still closes the run.
// The item carrying last starts the evaluation; in_ready stays low until the
// result is placed in the output register.
// Evaluation: a pass reads both sample stores (one registered read port
// each) and accumulates sums of squares and products.
// Then up to nine wide products go through one shared shift-add multiplier,
// a 32 step divider and an 18 step square root.
// Runs found degenerate on their last item skip the evaluation.
// The result waits in the output register until out_ready; loading of the
// next run proceeds meanwhile, and a later result waits for the register.
// mode is sampled with the last item of a run.
// Reset clears the counters and the mode register; store contents are kept
// undefined and are only read where written in the current run.
`default_nettype none
module correlation_coefficient_unit
  import ccu_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic                          cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] x_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] y_sample,
  input  wire logic                          last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COEF_BITS-1:0]        coefficient,
  output logic [1:0]                         status
);
  localparam int AW   = $clog2(MAX_SAMPLES);
  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int SUMW = SAMPLE_BITS + AW;
  localparam int PW   = 2 * SAMPLE_BITS + 3 * CW;
  localparam int DW   = 2 * PW;
  localparam int RW   = DW + 2;
  localparam int QCW  = $clog2(QUOT_BITS);
  localparam int BCW  = $clog2(ROOT_BITS);
  localparam logic [3:0] CHK_PEARSON  = 4'd5;
  localparam logic [3:0] LAST_PEARSON = 4'd7;
  localparam logic [3:0] CHK_CLASS    = 4'd3;
  localparam logic [3:0] LAST_CLASS   = 4'd8;
  localparam logic [ROOT_BITS-1:0] SAT_POS = ROOT_BITS'((1 << (COEF_BITS - 1)) - 1);
  localparam logic [ROOT_BITS-1:0] SAT_NEG = ROOT_BITS'(1 << (COEF_BITS - 1));

  typedef enum logic [2:0] {
    ST_LOAD, ST_PASS, ST_MUL, ST_MWAIT, ST_DIV, ST_SQRT, ST_OUT
  } state_t;

  state_t state;

  logic signed [SAMPLE_BITS-1:0] x_mem [MAX_SAMPLES];
  logic signed [SAMPLE_BITS-1:0] y_mem [MAX_SAMPLES];

  logic                   mode;
  logic                   mode_run;
  logic [CW-1:0]          sample_count;
  logic signed [SUMW-1:0] sum_x;
  logic signed [SUMW-1:0] sum_y;
  logic [CW-1:0]          class_one_count;
  logic [CW-1:0]          n_run;
  logic [CW-1:0]          c1_run;
  logic signed [SUMW-1:0] sx_run;
  logic signed [SUMW-1:0] sy_run;

  logic [CW-1:0]                 ptr;
  logic                          rd_v;
  logic                          p_v;
  logic signed [SAMPLE_BITS-1:0] x_rd;
  logic signed [SAMPLE_BITS-1:0] y_rd;
  logic signed [SAMPLE_BITS-1:0] x_d;
  logic                          ynz_d;
  logic signed [2*SAMPLE_BITS-1:0] pxx;
  logic signed [2*SAMPLE_BITS-1:0] pyy;
  logic signed [2*SAMPLE_BITS-1:0] pxy;
  logic signed [PW-1:0] sxx;
  logic signed [PW-1:0] syy;
  logic signed [PW-1:0] sxy;
  logic signed [PW-1:0] s1;

  logic [3:0]           step;
  logic signed [PW-1:0] t1;
  logic signed [PW-1:0] ra;
  logic signed [PW-1:0] rb;
  logic signed [PW-1:0] rc;
  logic [DW-1:0]        num;
  logic [DW-1:0]        den;

  logic [RW-1:0]        rem;
  logic [QUOT_BITS-1:0] quot;
  logic [QCW-1:0]       dcnt;
  logic [ROOT_BITS-1:0] root;
  logic [BCW-1:0]       bcnt;

  logic [COEF_BITS-1:0] res_coef;
  logic [1:0]           res_status;

  logic                 mul_start;
  logic                 mul_done;
  logic [DW-1:0]        mul_p;
  logic signed [PW-1:0] op_a;
  logic signed [PW-1:0] op_b;

  logic                   in_acc;
  logic                   room;
  logic                   rd_en;
  logic [CW-1:0]          count_next;
  logic signed [SUMW-1:0] sum_x_next;
  logic signed [SUMW-1:0] sum_y_next;
  logic [CW-1:0]          c1_next;
  logic [CW-1:0]          c0_run;
  logic signed [PW-1:0]   s0;
  logic signed [PW-1:0]   prod_lo;
  logic signed [PW-1:0]   diff;
  logic [RW-1:0]          rem_sh;
  logic [RW-1:0]          dcmp;
  logic                   dge;
  logic [ROOT_BITS-1:0]   cand;
  logic [2*ROOT_BITS-1:0] cand_sq;
  logic [ROOT_BITS-1:0]   root_next;
  logic [ROOT_BITS-1:0]   magc;
  logic                   chk_step;
  logic                   end_step;

  assign in_ready   = (state == ST_LOAD);
  assign in_acc     = in_valid && in_ready;
  assign room       = sample_count < CW'(MAX_SAMPLES);
  assign count_next = room ? sample_count + 1'b1 : sample_count;
  assign sum_x_next = room ? sum_x + SUMW'(x_sample) : sum_x;
  assign sum_y_next = room ? sum_y + SUMW'(y_sample) : sum_y;
  assign c1_next    = (room && (y_sample != '0)) ? class_one_count + 1'b1 : class_one_count;
  assign rd_en      = (state == ST_PASS) && (ptr < n_run);

  assign c0_run  = n_run - c1_run;
  assign s0      = PW'(sx_run) - s1;
  assign prod_lo = mul_p[PW-1:0];
  assign diff    = t1 - prod_lo;

  assign rem_sh  = (dcnt >= QCW'(2)) ? rem << 1 : rem;
  assign dcmp    = (dcnt == '0) ? RW'({den, 1'b0}) : RW'(den);
  assign dge     = rem_sh >= dcmp;

  assign cand      = root | (ROOT_BITS'(1) << bcnt);
  assign cand_sq   = cand * cand;
  assign root_next = (cand_sq <= (2*ROOT_BITS)'(quot)) ? cand : root;

  assign chk_step = mode_run ? (step == CHK_CLASS) : (step == CHK_PEARSON);
  assign end_step = mode_run ? (step == LAST_CLASS) : (step == LAST_PEARSON);

  always_comb begin
    op_a = t1;
    op_b = t1;
    if (!mode_run) begin
      case (step)
        4'd0: begin op_a = PW'(n_run);  op_b = sxy;         end
        4'd1: begin op_a = PW'(sx_run); op_b = PW'(sy_run); end
        4'd2: begin op_a = PW'(n_run);  op_b = sxx;         end
        4'd3: begin op_a = PW'(sx_run); op_b = PW'(sx_run); end
        4'd4: begin op_a = PW'(n_run);  op_b = syy;         end
        4'd5: begin op_a = PW'(sy_run); op_b = PW'(sy_run); end
        4'd6: begin op_a = ra;          op_b = ra;          end
        default: begin op_a = rb;       op_b = rc;          end
      endcase
    end else begin
      case (step)
        4'd0: begin op_a = s0;          op_b = PW'(c1_run);  end
        4'd1: begin op_a = s1;          op_b = PW'(c0_run);  end
        4'd2: begin op_a = PW'(n_run);  op_b = sxx;          end
        4'd3: begin op_a = PW'(sx_run); op_b = PW'(sx_run);  end
        4'd4: begin op_a = ra;          op_b = PW'(n_run - 1'b1); end
        4'd5: begin op_a = ra;          op_b = t1;           end
        4'd6: begin op_a = PW'(n_run);  op_b = PW'(c0_run);  end
        4'd7: begin op_a = t1;          op_b = PW'(c1_run);  end
        default: begin op_a = t1;       op_b = rb;           end
      endcase
    end
  end

  always_comb begin
    if (ra[PW-1]) begin
      magc = (root_next > SAT_NEG) ? SAT_NEG : root_next;
    end else begin
      magc = (root_next > SAT_POS) ? SAT_POS : root_next;
    end
  end

  ccu_mul #(.PW(PW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (in_acc && room) begin
      x_mem[sample_count[AW-1:0]] <= x_sample;
      y_mem[sample_count[AW-1:0]] <= y_sample;
    end
    if (rd_en) begin
      x_rd <= x_mem[ptr[AW-1:0]];
      y_rd <= y_mem[ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_LOAD;
      mode            <= 1'b0;
      sample_count    <= '0;
      sum_x           <= '0;
      sum_y           <= '0;
      class_one_count <= '0;
      out_valid       <= 1'b0;
      mul_start       <= 1'b0;
      rd_v            <= 1'b0;
      p_v             <= 1'b0;
      ptr             <= '0;
      step            <= '0;
      dcnt            <= '0;
      bcnt            <= '0;
    end else begin
      mul_start <= (state == ST_MUL);
      if (cfg_write) begin
        mode <= cfg_data;
      end
      out_valid <= (state == ST_OUT) || (out_valid && !out_ready);
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (last) begin
              sample_count    <= '0;
              sum_x           <= '0;
              sum_y           <= '0;
              class_one_count <= '0;
              n_run    <= count_next;
              sx_run   <= sum_x_next;
              sy_run   <= sum_y_next;
              c1_run   <= c1_next;
              mode_run <= mode;
              res_coef <= '0;
              ptr      <= '0;
              rd_v     <= 1'b0;
              p_v      <= 1'b0;
              sxx      <= '0;
              syy      <= '0;
              sxy      <= '0;
              s1       <= '0;
              if (count_next < CW'(2)) begin
                res_status <= STATUS_DEGEN;
                state      <= ST_OUT;
              end else if (mode && (c1_next == '0 || c1_next == count_next)) begin
                res_status <= STATUS_EMPTY;
                state      <= ST_OUT;
              end else begin
                res_status <= STATUS_OK;
                state      <= ST_PASS;
              end
            end else begin
              sample_count    <= count_next;
              sum_x           <= sum_x_next;
              sum_y           <= sum_y_next;
              class_one_count <= c1_next;
            end
          end
        end
        ST_PASS: begin
          if (rd_en) begin
            ptr <= ptr + 1'b1;
          end
          rd_v <= rd_en;
          p_v  <= rd_v;
          if (rd_v) begin
            pxx   <= x_rd * x_rd;
            pyy   <= y_rd * y_rd;
            pxy   <= x_rd * y_rd;
            x_d   <= x_rd;
            ynz_d <= (y_rd != '0);
          end
          if (p_v) begin
            sxx <= sxx + PW'(pxx);
            syy <= syy + PW'(pyy);
            sxy <= sxy + PW'(pxy);
            if (ynz_d) begin
              s1 <= s1 + PW'(x_d);
            end
          end
          if (!rd_en && !rd_v && !p_v) begin
            step  <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_MWAIT;
        end
        ST_MWAIT: begin
          if (mul_done) begin
            if (!mode_run) begin
              case (step)
                4'd1: ra  <= diff;
                4'd3: rb  <= diff;
                4'd5: rc  <= diff;
                4'd6: num <= mul_p;
                4'd7: den <= mul_p;
                default: t1 <= prod_lo;
              endcase
            end else begin
              case (step)
                4'd1: ra  <= diff;
                4'd3: rb  <= diff;
                4'd5: num <= mul_p;
                4'd8: den <= mul_p;
                default: t1 <= prod_lo;
              endcase
            end
            step <= step + 1'b1;
            if (chk_step && (diff == '0 || (!mode_run && rb == '0))) begin
              res_status <= STATUS_DEGEN;
              state      <= ST_OUT;
            end else if (end_step) begin
              rem   <= RW'(num);
              quot  <= '0;
              dcnt  <= '0;
              state <= ST_DIV;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_DIV: begin
          rem  <= dge ? rem_sh - dcmp : rem_sh;
          quot <= {quot[QUOT_BITS-2:0], dge};
          dcnt <= dcnt + 1'b1;
          if (dcnt == QCW'(QUOT_BITS - 1)) begin
            root  <= '0;
            bcnt  <= BCW'(ROOT_BITS - 1);
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          root <= root_next;
          bcnt <= bcnt - 1'b1;
          if (bcnt == '0) begin
            res_coef <= COEF_BITS'(ra[PW-1] ? ROOT_BITS'(0) - magc : magc);
            state    <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            coefficient <= res_coef;
            status      <= res_status;
            state       <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state == ST_PASS) |-> (ptr <= n_run))
    else $error("read pointer ran past the run");
  assert property (@(posedge clk) disable iff (rst) mul_done |-> (state == ST_MWAIT))
    else $error("product arrived outside a wait");
  assert property (@(posedge clk) disable iff (rst) p_v |-> $past(rd_v))
    else $error("accumulate without a store read");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_OK) |-> (coefficient == '0))
    else $error("flagged result carries a coefficient");
endmodule
`default_nettype wire
